@@ rtl/core/bfsa_pkg.sv @@
// Shared constants and types for the bitmap free-slot allocator.
`timescale 1ns / 1ps

package bfsa_pkg;

   // Default bitmap size in bytes
   localparam int MAP_BYTES_DEF = 128;

   // Field widths
   localparam int KIND_W     = 2;
   localparam int BITPOS_W   = 10;
   localparam int BYTE_IDX_W = 7;
   localparam int BYTE_VAL_W = 8;
   localparam int SLOT_W     = 11;
   localparam int COUNT_W    = 11;
   localparam int MAPB_W     = 8;
   localparam int RESV_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Bits in one bitmap byte, and its bit-index width
   localparam int BYTE_BITS = 8;
   localparam int BSEL_W    = 3;

   // Free counter limits and register reset values
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 11'd1024;
   localparam logic [MAPB_W-1:0]  MAP_BYTES_RST = 8'd16;

   // Item kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_SEARCH  = 2'd0,
      KIND_CLAIM   = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_LOAD    = 2'd3
   } kind_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_BYTES  = 2'd0,
      CSR_RESERVED   = 2'd1,
      CSR_FREE_START = 2'd2
   } csr_idx_type;

endpackage

@@ rtl/core/bfsa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module bfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/bitmap_free_slot_allocator_unit.sv @@
// Bitmap free-slot allocator: sequencer, bitmap RAM, free counter, config registers.
// Search reads one bitmap byte per cycle through the single RAM read port from byte 0
// up to min(map_bytes, MAP_BYTES), until a free bit is found; claim and release read
// the byte and write it back, load writes it directly. One item is in flight at a time;
// the result register lets the next item start while a result waits on rsp_stall.
// Reset is synchronous; afterwards a clearing pass zeroes every bitmap byte, during
// which no item is accepted (register writes are taken).
`timescale 1ns / 1ps

module bitmap_free_slot_allocator_unit
   import bfsa_pkg::*;
#(
   parameter int MAP_BYTES = MAP_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [BITPOS_W-1:0]   req_bit_position,
   input  logic [BYTE_IDX_W-1:0] req_byte_index,
   input  logic [BYTE_VAL_W-1:0] req_byte_value,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [SLOT_W-1:0]     rsp_slot_number,
   output logic [COUNT_W-1:0]    rsp_free_count,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Derived widths
   localparam int AW     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAP_BYTES + 1);
   localparam int CW     = (CNT_W > MAPB_W) ? CNT_W : MAPB_W;
   localparam int RB_W   = (AW > BYTE_IDX_W) ? AW : BYTE_IDX_W;
   localparam int POS_W  = AW + BSEL_W;
   localparam int SUM_W  = (POS_W > SLOT_W) ? POS_W : SLOT_W;
   localparam logic [CW-1:0] MAP_LIM  = CW'(MAP_BYTES);
   localparam logic [AW-1:0] LAST_IDX = AW'(MAP_BYTES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_MODIFY,
      ST_RESULT
   } state_type;

   // Sequencer and datapath registers
   state_type               state_ff,      state_in;
   logic [AW-1:0]           clr_idx_ff,    clr_idx_in;
   logic [CW-1:0]           issue_idx_ff,  issue_idx_in;
   logic [AW-1:0]           chk_idx_ff,    chk_idx_in;
   logic                    chk_valid_ff,  chk_valid_in;
   logic [AW-1:0]           mod_addr_ff,   mod_addr_in;
   logic                    mod_ok_ff,     mod_ok_in;
   logic                    mod_claim_ff,  mod_claim_in;
   logic [BYTE_BITS-1:0]    mod_mask_ff,   mod_mask_in;
   logic                    res_found_ff,  res_found_in;
   logic [SLOT_W-1:0]       res_slot_ff,   res_slot_in;
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic                    rsp_found_ff,  rsp_found_in;
   logic [SLOT_W-1:0]       rsp_slot_ff,   rsp_slot_in;
   logic [COUNT_W-1:0]      rsp_count_ff,  rsp_count_in;

   // Config registers and free counter
   logic [MAPB_W-1:0]       map_bytes_ff,  map_bytes_in;
   logic [RESV_W-1:0]       reserved_ff,   reserved_in;
   logic [COUNT_W-1:0]      free_cnt_ff,   free_cnt_in;

   // RAM port signals
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [BYTE_BITS-1:0]    ram_wdata;
   logic                    ram_re;
   logic [AW-1:0]           ram_raddr;
   logic [BYTE_BITS-1:0]    ram_rdata;

   // Handshake helpers
   logic                    req_take;
   logic                    out_free;
   kind_type                kind;

   // Request decode
   logic [BYTE_IDX_W-1:0]   bp_byte;
   logic [AW-1:0]           bp_addr;
   logic                    bp_ok;
   logic [AW-1:0]           ld_addr;
   logic                    ld_ok;

   // Search datapath
   logic [CW-1:0]           limit;
   logic [RB_W-1:0]         cmp_byte;
   logic [RB_W-1:0]         res_byte;
   logic [BYTE_BITS-1:0]    allowed;
   logic [BYTE_BITS-1:0]    free_bits;
   logic                    hit;
   logic [BSEL_W-1:0]       first_bit;
   logic [SUM_W-1:0]        slot_sum;

   // Counter update from a claim or release
   logic [COUNT_W-1:0]      cnt_step;

   bfsa_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (MAP_BYTES),
      .AW    (AW)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign kind      = kind_type'(req_kind);
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot_number = rsp_slot_ff;
   assign rsp_free_count  = rsp_count_ff;

   // Byte addresses of claim/release and load, with range checks
   always_comb begin
      logic [RB_W-1:0] bp_ext;
      logic [RB_W-1:0] ld_ext;
      bp_byte = req_bit_position[BITPOS_W-1:BSEL_W];
      bp_ext  = RB_W'(bp_byte);
      ld_ext  = RB_W'(req_byte_index);
      bp_addr = bp_ext[AW-1:0];
      ld_addr = ld_ext[AW-1:0];
      bp_ok   = CW'(bp_byte) < MAP_LIM;
      ld_ok   = CW'(req_byte_index) < MAP_LIM;
   end

   // Search limit: map_bytes capped at the store size
   assign limit = (CW'(map_bytes_ff) > MAP_LIM) ? MAP_LIM : CW'(map_bytes_ff);

   // First free bit of the byte under check at or above reserved_bits
   always_comb begin
      cmp_byte = RB_W'(chk_idx_ff);
      res_byte = RB_W'(reserved_ff[RESV_W-1:BSEL_W]);
      for (int k = 0; k < BYTE_BITS; k++) begin
         allowed[k] = (cmp_byte > res_byte) ||
                      ((cmp_byte == res_byte) && (BSEL_W'(k) >= reserved_ff[BSEL_W-1:0]));
      end
      free_bits = ~ram_rdata & allowed;
      hit       = |free_bits;
      first_bit = '0;
      for (int k = BYTE_BITS - 1; k >= 0; k--) begin
         if (free_bits[k]) begin
            first_bit = BSEL_W'(k);
         end
      end
      slot_sum = SUM_W'({chk_idx_ff, first_bit}) + SUM_W'(1);
   end

   // Saturating counter step
   always_comb begin
      if (mod_claim_ff) begin
         cnt_step = (free_cnt_ff != '0) ? free_cnt_ff - COUNT_W'(1) : free_cnt_ff;
      end else begin
         cnt_step = (free_cnt_ff < COUNT_MAX) ? free_cnt_ff + COUNT_W'(1) : free_cnt_ff;
      end
   end

   // Sequencer next state, RAM control and result capture
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      issue_idx_in = issue_idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = 1'b0;
      mod_addr_in  = mod_addr_ff;
      mod_ok_in    = mod_ok_ff;
      mod_claim_in = mod_claim_ff;
      mod_mask_in  = mod_mask_ff;
      res_found_in = res_found_ff;
      res_slot_in  = res_slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      free_cnt_in  = free_cnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_idx_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = issue_idx_ff[AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               res_found_in = 1'b0;
               res_slot_in  = '0;
               unique case (kind)
                  KIND_SEARCH: begin
                     issue_idx_in = '0;
                     state_in     = ST_SEARCH;
                  end
                  KIND_CLAIM, KIND_RELEASE: begin
                     ram_re       = 1'b1;
                     ram_raddr    = bp_addr;
                     mod_addr_in  = bp_addr;
                     mod_ok_in    = bp_ok;
                     mod_claim_in = (kind == KIND_CLAIM);
                     mod_mask_in  = BYTE_BITS'(1) << req_bit_position[BSEL_W-1:0];
                     state_in     = ST_MODIFY;
                  end
                  KIND_LOAD: begin
                     ram_we    = ld_ok;
                     ram_waddr = ld_addr;
                     ram_wdata = req_byte_value;
                     state_in  = ST_RESULT;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (chk_valid_ff && hit) begin
               res_found_in = 1'b1;
               res_slot_in  = slot_sum[SLOT_W-1:0];
               state_in     = ST_RESULT;
            end else if (!chk_valid_ff && (issue_idx_ff >= limit)) begin
               res_found_in = 1'b0;
               res_slot_in  = '0;
               state_in     = ST_RESULT;
            end else if (issue_idx_ff < limit) begin
               ram_re       = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_idx_ff[AW-1:0];
               issue_idx_in = issue_idx_ff + CW'(1);
            end
         end
         ST_MODIFY: begin
            ram_we      = mod_ok_ff;
            ram_waddr   = mod_addr_ff;
            ram_wdata   = mod_claim_ff ? (ram_rdata | mod_mask_ff) : (ram_rdata & ~mod_mask_ff);
            free_cnt_in = cnt_step;
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_count_in = free_cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Loading free_start sets the counter
      if (csr_valid && csr_ready && (csr_idx_type'(csr_index) == CSR_FREE_START)) begin
         free_cnt_in = (csr_wdata > COUNT_MAX) ? COUNT_MAX : csr_wdata;
      end
   end

   // Register writes
   always_comb begin
      map_bytes_in = map_bytes_ff;
      reserved_in  = reserved_ff;
      if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_MAP_BYTES: map_bytes_in = csr_wdata[MAPB_W-1:0];
            CSR_RESERVED:  reserved_in  = csr_wdata[RESV_W-1:0];
            default: ;
         endcase
      end
   end

   // State, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         map_bytes_ff <= MAP_BYTES_RST;
         reserved_ff  <= '0;
         free_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         map_bytes_ff <= map_bytes_in;
         reserved_ff  <= reserved_in;
         free_cnt_ff  <= free_cnt_in;
      end
      issue_idx_ff <= issue_idx_in;
      chk_idx_ff   <= chk_idx_in;
      mod_addr_ff  <= mod_addr_in;
      mod_ok_ff    <= mod_ok_in;
      mod_claim_ff <= mod_claim_in;
      mod_mask_ff  <= mod_mask_in;
      res_found_ff <= res_found_in;
      res_slot_ff  <= res_slot_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Checks
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT)))
      else $error("result raised outside the result state");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (free_cnt_ff <= COUNT_MAX))
      else $error("free counter above its limit");

   a_no_slot_when_missed: assert property (@(posedge clock) disable iff (reset)
      ((rsp_valid_ff && !rsp_found_ff) |-> (rsp_slot_ff == '0)))
      else $error("slot number set without a hit");

   a_check_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEARCH && chk_valid_ff) |-> (CW'(chk_idx_ff) < limit)))
      else $error("search checked a byte beyond the limit");

endmodule
